// ===== src/dwc_pkg.sv =====
// ---------------------------------------------------------------------------
// dwc_pkg: shared types and constants
// Item formats, request and result codes, sequencer states and the word
// separator test used by the distinct word counter.
// ---------------------------------------------------------------------------
`default_nettype none

package dwc_pkg;

  // Request codes carried by an input item.
  typedef enum logic [1:0] {
    REQ_BYTE  = 2'd0,
    REQ_EOD   = 2'd1,
    REQ_QUERY = 2'd2
  } req_code_t;

  // Result kinds.
  localparam logic KIND_EOD   = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  // djb2 hash constants.
  localparam logic [31:0] HASH_SEED  = 32'd5381;
  localparam int unsigned HASH_SHIFT = 5;

  // Separator characters.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // One input item.
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] text_byte;
  } req_t;

  // One result item.
  typedef struct packed {
    logic        result_kind;
    logic [13:0] distinct_words;
    logic        store_full;
    logic        word_truncated;
  } res_t;

  // Write strobes from the sequencer to the word store.
  typedef struct packed {
    logic buf_we;
    logic chars_we;
    logic len_we;
    logic next_we;
    logic head_we;
  } store_we_t;

  // What ends the word being finished.
  typedef enum logic [1:0] {
    PEND_SEP = 2'd0,
    PEND_NUL = 2'd1,
    PEND_EOD = 2'd2
  } pend_t;

  // Sequencer states.
  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_CLEAR     = 14'b00000000000010,
    S_MOD       = 14'b00000000000100,
    S_HEAD      = 14'b00000000001000,
    S_HEAD_GET  = 14'b00000000010000,
    S_LINK_CHK  = 14'b00000000100000,
    S_ENTRY     = 14'b00000001000000,
    S_CMP_RD    = 14'b00000010000000,
    S_CMP_CHK   = 14'b00000100000000,
    S_COPY_RD   = 14'b00001000000000,
    S_COPY_WR   = 14'b00010000000000,
    S_LINK_NEW  = 14'b00100000000000,
    S_LINK_PREV = 14'b01000000000000,
    S_FINISH    = 14'b10000000000000
  } state_t;

  // True for space, tab, CR and LF.
  function automatic logic is_sep(input logic [7:0] c);
    is_sep = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

`default_nettype wire

// ===== src/dwc_hash_mod.sv =====
// ---------------------------------------------------------------------------
// dwc_hash_mod: bucket index unit
// Reduces a 32-bit hash modulo the bucket count. The bucket count is a power
// of two, so the remainder is the low hash bits, registered on start.
// ---------------------------------------------------------------------------
`default_nettype none

module dwc_hash_mod #(
  parameter int unsigned BUCKETS = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [31:0]                value,
  output logic                            done,
  output logic [$clog2(BUCKETS)-1:0]      rem
);
  import dwc_pkg::*;

  localparam int unsigned BW = $clog2(BUCKETS);

  // Register the low hash bits when start is high; done rises in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        rem <= value[BW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/dwc_word_store.sv =====
// ---------------------------------------------------------------------------
// dwc_word_store: bucket table, entry store and word buffer
// Single write port and one registered read port per memory.
// ---------------------------------------------------------------------------
`default_nettype none

module dwc_word_store #(
  parameter int unsigned BUCKETS      = 4096,
  parameter int unsigned MAX_WORDS    = 8192,
  parameter int unsigned MAX_WORD_LEN = 32
) (
  input  wire logic                                        clk,
  input  wire dwc_pkg::store_we_t                          we,
  input  wire logic [$clog2(MAX_WORD_LEN)-1:0]             buf_waddr,
  input  wire logic [7:0]                                  buf_wdata,
  input  wire logic [$clog2(MAX_WORD_LEN)-1:0]             buf_raddr,
  output logic [7:0]                                       buf_rdata,
  input  wire logic [$clog2(BUCKETS)-1:0]                  head_raddr,
  input  wire logic [$clog2(BUCKETS)-1:0]                  head_waddr,
  input  wire logic [$clog2(MAX_WORDS+1)-1:0]              head_wdata,
  output logic [$clog2(MAX_WORDS+1)-1:0]                   head_rdata,
  input  wire logic [$clog2(MAX_WORDS)-1:0]                ent_raddr,
  input  wire logic [$clog2(MAX_WORDS)-1:0]                ent_waddr,
  input  wire logic [$clog2(MAX_WORD_LEN+1)-1:0]           len_wdata,
  input  wire logic [$clog2(MAX_WORDS+1)-1:0]              next_wdata,
  output logic [$clog2(MAX_WORD_LEN+1)-1:0]                len_rdata,
  output logic [$clog2(MAX_WORDS+1)-1:0]                   next_rdata,
  input  wire logic [$clog2(MAX_WORDS)+$clog2(MAX_WORD_LEN)-1:0] chars_raddr,
  input  wire logic [$clog2(MAX_WORDS)+$clog2(MAX_WORD_LEN)-1:0] chars_waddr,
  input  wire logic [7:0]                                  chars_wdata,
  output logic [7:0]                                       chars_rdata
);
  import dwc_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_WORDS);
  localparam int unsigned PW  = $clog2(MAX_WORD_LEN);
  localparam int unsigned LW  = $clog2(MAX_WORDS+1);
  localparam int unsigned LNW = $clog2(MAX_WORD_LEN+1);

  logic [7:0]     word_buffer  [0:MAX_WORD_LEN-1];
  logic [LW-1:0]  bucket_head  [0:BUCKETS-1];
  logic [LW-1:0]  entry_next   [0:MAX_WORDS-1];
  logic [LNW-1:0] entry_length [0:MAX_WORDS-1];
  logic [7:0]     entry_chars  [0:(1 << (IW+PW))-1];

  // Word being collected.
  always_ff @(posedge clk) begin
    if (we.buf_we) begin
      word_buffer[buf_waddr] <= buf_wdata;
    end
    buf_rdata <= word_buffer[buf_raddr];
  end

  // Chain heads, one per bucket.
  always_ff @(posedge clk) begin
    if (we.head_we) begin
      bucket_head[head_waddr] <= head_wdata;
    end
    head_rdata <= bucket_head[head_raddr];
  end

  // Entry length and chain link.
  always_ff @(posedge clk) begin
    if (we.len_we) begin
      entry_length[ent_waddr] <= len_wdata;
    end
    if (we.next_we) begin
      entry_next[ent_waddr] <= next_wdata;
    end
    len_rdata  <= entry_length[ent_raddr];
    next_rdata <= entry_next[ent_raddr];
  end

  // Stored characters, one row per entry.
  always_ff @(posedge clk) begin
    if (we.chars_we) begin
      entry_chars[chars_waddr] <= chars_wdata;
    end
    chars_rdata <= entry_chars[chars_raddr];
  end

endmodule

`default_nettype wire

// ===== src/distinct_word_counter.sv =====
// ---------------------------------------------------------------------------
// distinct_word_counter: distinct word count over a text byte stream
// Splits text into words, hashes each word into a bucket chain and counts
// the words that are new.
// ---------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. A text byte that
//   adds to a word, or a separator after a separator, is taken without
//   busy going high. A byte that ends a word, and an end-of-document item
//   that ends a word, run the word finish: wait for the bucket from the low
//   hash bits, read the chain head, then for each chain entry visited read
//   its length and link, and read and compare each character in turn. A new
//   word then checks the chain end, reads and writes each character copied
//   and links the entry, and every finish ends with a closing step. The
//   entry memory's single read port means characters go one at a time.
//   End of document answers with result_kind 0 in the cycle after the finish,
//   or after the accept when no word is open; a query answers with result_kind 1
//   on the next cycle and then clears the bucket table with busy high.
//   Results appear on result for one cycle with result_valid high; the
//   receiver cannot stall.
//   After reset the block clears the bucket table with busy high before it
//   takes its first item.
// ---------------------------------------------------------------------------
`default_nettype none

module distinct_word_counter #(
  parameter int unsigned BUCKETS      = 4096,
  parameter int unsigned MAX_WORDS    = 8192,
  parameter int unsigned MAX_WORD_LEN = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire dwc_pkg::req_t request,
  output logic               busy,
  output logic               result_valid,
  output dwc_pkg::res_t      result
);
  import dwc_pkg::*;

  localparam int unsigned BW  = $clog2(BUCKETS);
  localparam int unsigned IW  = $clog2(MAX_WORDS);
  localparam int unsigned PW  = $clog2(MAX_WORD_LEN);
  localparam int unsigned LW  = $clog2(MAX_WORDS+1);
  localparam int unsigned LNW = $clog2(MAX_WORD_LEN+1);

  state_t          state;
  pend_t           pend;
  logic [LNW-1:0]  word_length;
  logic [31:0]     word_hash;
  logic [LW-1:0]   distinct_count;
  logic            text_ended;
  logic            full_flag;
  logic            trunc_flag;
  logic [BW-1:0]   bucket;
  logic [BW-1:0]   clear_addr;
  logic [LW-1:0]   link;
  logic [LW-1:0]   next_link;
  logic [IW-1:0]   idx;
  logic [IW-1:0]   prev;
  logic            has_prev;
  logic [PW-1:0]   pos;

  logic            accept;
  logic            mod_start;
  logic            mod_done;
  logic [BW-1:0]   mod_rem;
  logic [7:0]      c;
  logic            byte_add;
  logic            last_pos;
  logic [31:0]     hash_next;
  logic [IW-1:0]   new_idx;
  logic [IW-1:0]   link_idx;

  store_we_t                we;
  logic [PW-1:0]            buf_raddr;
  logic [7:0]               buf_rdata;
  logic [BW-1:0]            head_waddr;
  logic [LW-1:0]            head_wdata;
  logic [LW-1:0]            head_rdata;
  logic [IW-1:0]            ent_raddr;
  logic [IW-1:0]            ent_waddr;
  logic [LW-1:0]            next_wdata;
  logic [LNW-1:0]           len_rdata;
  logic [LW-1:0]            next_rdata;
  logic [IW+PW-1:0]         chars_raddr;
  logic [IW+PW-1:0]         chars_waddr;
  logic [7:0]               chars_rdata;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign c        = request.text_byte;
  assign new_idx  = distinct_count[IW-1:0];
  assign link_idx = IW'(link - LW'(1));
  assign last_pos = ((LNW'(pos) + LNW'(1)) == word_length);

  // A plain text byte is added to the word in the accept cycle.
  assign byte_add = accept && (request.req_type == REQ_BYTE) && !text_ended &&
                    (c != CH_NUL) && !is_sep(c) &&
                    (word_length != LNW'(MAX_WORD_LEN));
  assign hash_next = (word_hash << HASH_SHIFT) + word_hash + {{24{c[7]}}, c};

  // Start the bucket reduction when an item ends a non-empty word.
  always_comb begin
    mod_start = 1'b0;
    if (accept && (word_length != '0)) begin
      if (request.req_type == REQ_EOD) begin
        mod_start = 1'b1;
      end else if (request.req_type == REQ_BYTE && !text_ended &&
                   ((c == CH_NUL) || is_sep(c))) begin
        mod_start = 1'b1;
      end
    end
  end

  // Store control by state.
  always_comb begin
    we          = '0;
    we.buf_we   = byte_add;
    buf_raddr   = pos;
    head_waddr  = bucket;
    head_wdata  = distinct_count + LW'(1);
    ent_raddr   = link_idx;
    ent_waddr   = new_idx;
    next_wdata  = '0;
    chars_raddr = {idx, pos};
    chars_waddr = {new_idx, pos};
    case (state)
      S_CLEAR: begin
        we.head_we = 1'b1;
        head_waddr = clear_addr;
        head_wdata = '0;
      end
      S_COPY_WR: begin
        we.chars_we = 1'b1;
      end
      S_LINK_NEW: begin
        we.len_we  = 1'b1;
        we.next_we = 1'b1;
      end
      S_LINK_PREV: begin
        if (has_prev) begin
          we.next_we = 1'b1;
          ent_waddr  = prev;
          next_wdata = distinct_count + LW'(1);
        end else begin
          we.head_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clear_addr     <= '0;
      word_length    <= '0;
      word_hash      <= HASH_SEED;
      distinct_count <= '0;
      text_ended     <= 1'b0;
      full_flag      <= 1'b0;
      trunc_flag     <= 1'b0;
      has_prev       <= 1'b0;
      result_valid   <= 1'b0;
      pend           <= PEND_SEP;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (request.req_type)
              REQ_BYTE: begin
                if (!text_ended) begin
                  if (c == CH_NUL) begin
                    pend <= PEND_NUL;
                    if (word_length == '0) begin
                      text_ended <= 1'b1;
                    end else begin
                      state <= S_MOD;
                    end
                  end else if (is_sep(c)) begin
                    pend <= PEND_SEP;
                    if (word_length != '0) begin
                      state <= S_MOD;
                    end
                  end else if (word_length == LNW'(MAX_WORD_LEN)) begin
                    trunc_flag <= 1'b1;
                  end else begin
                    word_length <= word_length + LNW'(1);
                    word_hash   <= hash_next;
                  end
                end
              end
              REQ_EOD: begin
                pend <= PEND_EOD;
                if (word_length == '0) begin
                  text_ended            <= 1'b0;
                  result_valid          <= 1'b1;
                  result.result_kind    <= KIND_EOD;
                  result.distinct_words <= 14'(distinct_count);
                  result.store_full     <= full_flag;
                  result.word_truncated <= trunc_flag;
                end else begin
                  state <= S_MOD;
                end
              end
              REQ_QUERY: begin
                result_valid          <= 1'b1;
                result.result_kind    <= KIND_COUNT;
                result.distinct_words <= 14'(distinct_count);
                result.store_full     <= full_flag;
                result.word_truncated <= trunc_flag;
                state          <= S_CLEAR;
                clear_addr     <= '0;
                word_length    <= '0;
                word_hash      <= HASH_SEED;
                distinct_count <= '0;
                text_ended     <= 1'b0;
                full_flag      <= 1'b0;
                trunc_flag     <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_CLEAR: begin
          clear_addr <= clear_addr + BW'(1);
          if (clear_addr == BW'(BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            bucket <= mod_rem;
            state  <= S_HEAD;
          end
        end
        S_HEAD: begin
          state <= S_HEAD_GET;
        end
        S_HEAD_GET: begin
          link  <= head_rdata;
          state <= S_LINK_CHK;
        end
        S_LINK_CHK: begin
          pos <= '0;
          if (link == '0) begin
            if (distinct_count == LW'(MAX_WORDS)) begin
              full_flag <= 1'b1;
              state     <= S_FINISH;
            end else begin
              state <= S_COPY_RD;
            end
          end else begin
            idx   <= link_idx;
            state <= S_ENTRY;
          end
        end
        S_ENTRY: begin
          next_link <= next_rdata;
          if (len_rdata == word_length) begin
            state <= S_CMP_RD;
          end else begin
            prev     <= idx;
            has_prev <= 1'b1;
            link     <= next_rdata;
            state    <= S_LINK_CHK;
          end
        end
        S_CMP_RD: begin
          state <= S_CMP_CHK;
        end
        S_CMP_CHK: begin
          if (chars_rdata == buf_rdata) begin
            if (last_pos) begin
              state <= S_FINISH;
            end else begin
              pos   <= pos + PW'(1);
              state <= S_CMP_RD;
            end
          end else begin
            prev     <= idx;
            has_prev <= 1'b1;
            link     <= next_link;
            state    <= S_LINK_CHK;
          end
        end
        S_COPY_RD: begin
          state <= S_COPY_WR;
        end
        S_COPY_WR: begin
          if (last_pos) begin
            state <= S_LINK_NEW;
          end else begin
            pos   <= pos + PW'(1);
            state <= S_COPY_RD;
          end
        end
        S_LINK_NEW: begin
          state <= S_LINK_PREV;
        end
        S_LINK_PREV: begin
          distinct_count <= distinct_count + LW'(1);
          state          <= S_FINISH;
        end
        S_FINISH: begin
          word_length <= '0;
          word_hash   <= HASH_SEED;
          has_prev    <= 1'b0;
          state       <= S_IDLE;
          case (pend)
            PEND_NUL: begin
              text_ended <= 1'b1;
            end
            PEND_EOD: begin
              text_ended            <= 1'b0;
              result_valid          <= 1'b1;
              result.result_kind    <= KIND_EOD;
              result.distinct_words <= 14'(distinct_count);
              result.store_full     <= full_flag;
              result.word_truncated <= trunc_flag;
            end
            default: begin
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  dwc_hash_mod #(
    .BUCKETS(BUCKETS)
  ) u_mod (
    .clk  (clk),
    .rst  (rst),
    .start(mod_start),
    .value(word_hash),
    .done (mod_done),
    .rem  (mod_rem)
  );

  dwc_word_store #(
    .BUCKETS     (BUCKETS),
    .MAX_WORDS   (MAX_WORDS),
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_store (
    .clk        (clk),
    .we         (we),
    .buf_waddr  (word_length[PW-1:0]),
    .buf_wdata  (c),
    .buf_raddr  (buf_raddr),
    .buf_rdata  (buf_rdata),
    .head_raddr (bucket),
    .head_waddr (head_waddr),
    .head_wdata (head_wdata),
    .head_rdata (head_rdata),
    .ent_raddr  (ent_raddr),
    .ent_waddr  (ent_waddr),
    .len_wdata  (word_length),
    .next_wdata (next_wdata),
    .len_rdata  (len_rdata),
    .next_rdata (next_rdata),
    .chars_raddr(chars_raddr),
    .chars_waddr(chars_waddr),
    .chars_wdata(buf_rdata),
    .chars_rdata(chars_rdata)
  );

  // A result comes only from an accepted item or the end of a word finish.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(state) == S_FINISH || $past(state) == S_IDLE))
    else $error("result without a source");

  // The count never passes the store size.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    distinct_count <= LW'(MAX_WORDS))
    else $error("distinct count out of range");

  // The bucket table is written only while clearing or linking.
  a_head_write: assert property (@(posedge clk) disable iff (rst)
    we.head_we |-> (state == S_CLEAR || state == S_LINK_PREV))
    else $error("unexpected bucket table write");

  // The remainder unit reports only while the sequencer waits for it.
  a_mod_done: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == S_MOD)
    else $error("remainder done outside its wait");

  // Linking always ends in the finish step.
  a_link_finish: assert property (@(posedge clk) disable iff (rst)
    state == S_LINK_PREV |=> state == S_FINISH)
    else $error("link step not followed by finish");

endmodule

`default_nettype wire
